// ----- rtl/core/opd_pkg.sv -----
`default_nettype none
package opd_pkg;

  localparam int unsigned ENTRY_COUNT = 60;
  localparam int unsigned INDEX_W     = 6;
  localparam int unsigned WORD_W      = 16;

  localparam logic [1:0] KIND_NONE   = 2'b00;
  localparam logic [1:0] KIND_MEM    = 2'b01;
  localparam logic [1:0] KIND_BRANCH = 2'b10;

  // operand bits of a memory operand, by addressing mode
  localparam logic [WORD_W-1:0] MEM_DIRECT_FREE   = 16'h007F;
  localparam logic [WORD_W-1:0] MEM_INDIRECT_FREE = 16'h00B9;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [INDEX_W-1:0] index_t;

  typedef struct packed {
    word_t      base;
    word_t      fixed_free;
    logic [1:0] kind;
  } pattern_t;

  function automatic pattern_t opd_pattern(input index_t idx);
    pattern_t p;
    p = '{base: 16'h0000, fixed_free: 16'h0000, kind: KIND_NONE};
    case (idx)
      6'd0:  p = '{16'h0000, 16'h0F00, KIND_MEM};
      6'd1:  p = '{16'h1000, 16'h0F00, KIND_MEM};
      6'd2:  p = '{16'h2000, 16'h0F00, KIND_MEM};
      6'd3:  p = '{16'h3000, 16'h0100, KIND_MEM};
      6'd4:  p = '{16'h3800, 16'h0100, KIND_MEM};
      6'd5:  p = '{16'h4000, 16'h0700, KIND_MEM};
      6'd6:  p = '{16'h4800, 16'h0700, KIND_MEM};
      6'd7:  p = '{16'h5000, 16'h0700, KIND_MEM};
      6'd8:  p = '{16'h5800, 16'h0700, KIND_MEM};
      6'd9:  p = '{16'h6000, 16'h0000, KIND_MEM};
      6'd10: p = '{16'h6100, 16'h0000, KIND_MEM};
      6'd11: p = '{16'h6200, 16'h0000, KIND_MEM};
      6'd12: p = '{16'h6300, 16'h0000, KIND_MEM};
      6'd13: p = '{16'h6400, 16'h0000, KIND_MEM};
      6'd14: p = '{16'h6500, 16'h0000, KIND_MEM};
      6'd15: p = '{16'h6600, 16'h0000, KIND_MEM};
      6'd16: p = '{16'h6700, 16'h0000, KIND_MEM};
      6'd17: p = '{16'h6880, 16'h0001, KIND_NONE};
      6'd18: p = '{16'h6800, 16'h0000, KIND_MEM};
      6'd19: p = '{16'h6900, 16'h0000, KIND_MEM};
      6'd20: p = '{16'h6A00, 16'h0000, KIND_MEM};
      6'd21: p = '{16'h6B00, 16'h0000, KIND_MEM};
      6'd22: p = '{16'h6C00, 16'h0000, KIND_MEM};
      6'd23: p = '{16'h6D00, 16'h0000, KIND_MEM};
      6'd24: p = '{16'h6E00, 16'h0001, KIND_NONE};
      6'd25: p = '{16'h6F00, 16'h0000, KIND_MEM};
      6'd26: p = '{16'h7000, 16'h01FF, KIND_NONE};
      6'd27: p = '{16'h7800, 16'h0000, KIND_MEM};
      6'd28: p = '{16'h7900, 16'h0000, KIND_MEM};
      6'd29: p = '{16'h7A00, 16'h0000, KIND_MEM};
      6'd30: p = '{16'h7B00, 16'h0000, KIND_MEM};
      6'd31: p = '{16'h7C00, 16'h0000, KIND_MEM};
      6'd32: p = '{16'h7D00, 16'h0000, KIND_MEM};
      6'd33: p = '{16'h7E00, 16'h00FF, KIND_NONE};
      6'd34: p = '{16'h7F80, 16'h0000, KIND_NONE};
      6'd35: p = '{16'h7F81, 16'h0000, KIND_NONE};
      6'd36: p = '{16'h7F82, 16'h0000, KIND_NONE};
      6'd37: p = '{16'h7F88, 16'h0000, KIND_NONE};
      6'd38: p = '{16'h7F89, 16'h0000, KIND_NONE};
      6'd39: p = '{16'h7F8A, 16'h0000, KIND_NONE};
      6'd40: p = '{16'h7F8B, 16'h0000, KIND_NONE};
      6'd41: p = '{16'h7F8C, 16'h0000, KIND_NONE};
      6'd42: p = '{16'h7F8D, 16'h0000, KIND_NONE};
      6'd43: p = '{16'h7F8E, 16'h0000, KIND_NONE};
      6'd44: p = '{16'h7F8F, 16'h0000, KIND_NONE};
      6'd45: p = '{16'h7F90, 16'h0000, KIND_NONE};
      6'd46: p = '{16'h7F9C, 16'h0000, KIND_NONE};
      6'd47: p = '{16'h7F9D, 16'h0000, KIND_NONE};
      6'd48: p = '{16'h8000, 16'h1FFF, KIND_NONE};
      6'd49: p = '{16'hF400, 16'h0000, KIND_BRANCH};
      6'd50: p = '{16'hF500, 16'h0000, KIND_BRANCH};
      6'd51: p = '{16'hF600, 16'h0000, KIND_BRANCH};
      6'd52: p = '{16'hF800, 16'h0000, KIND_BRANCH};
      6'd53: p = '{16'hF900, 16'h0000, KIND_BRANCH};
      6'd54: p = '{16'hFA00, 16'h0000, KIND_BRANCH};
      6'd55: p = '{16'hFB00, 16'h0000, KIND_BRANCH};
      6'd56: p = '{16'hFC00, 16'h0000, KIND_BRANCH};
      6'd57: p = '{16'hFD00, 16'h0000, KIND_BRANCH};
      6'd58: p = '{16'hFE00, 16'h0000, KIND_BRANCH};
      6'd59: p = '{16'hFF00, 16'h0000, KIND_BRANCH};
      default: p = '{base: 16'h0000, fixed_free: 16'h0000, kind: KIND_NONE};
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/opd_in_if.sv -----
`default_nettype none
interface opd_in_if
  import opd_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/opd_out_if.sv -----
`default_nettype none
interface opd_out_if
  import opd_pkg::*;
;
  logic   valid;
  logic   ready;
  logic   matched;
  index_t entry_index;
  word_t  operand_bits;
  logic   second_word;

  modport source (output valid, output matched, output entry_index,
                  output operand_bits, output second_word, input ready);
  modport sink   (input valid, input matched, input entry_index,
                  input operand_bits, input second_word, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/dsp_opcode_pattern_decoder_core.sv -----
// Opcode pattern decoder: one 16-bit instruction word in, one decode word out.
// in_ch (sink): instr_word with valid/ready; a word is taken when both are high.
// out_ch (source): matched, entry_index, operand_bits, second_word with
// valid/ready. matched is 0 for an illegal word, and then all other fields
// are 0. second_word flags a branch whose program address word follows.
// Pipeline: a taken word is registered in in_word_r, and its decode is then
// registered in the out_ch result registers. Throughput: one word per cycle,
// sustained under a receiver that takes every cycle; the rate is set by the
// single compare stage that matches the registered word against all 60 table
// entries in parallel and picks the first hit in table order.
// Stall: when out_ch is not taken the result holds, the input register fills
// once more if it is empty, and then in_ch.ready drops until the result drains.
// Reset (rst_n low, synchronous): both valid flags clear, no result is
// pending, and in_ch.ready is high in the following cycle.
`default_nettype none
module dsp_opcode_pattern_decoder_core
  import opd_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  opd_in_if.sink     in_ch,
  opd_out_if.source  out_ch
);

  logic   in_valid_r;
  word_t  in_word_r;

  logic   out_valid_r;
  logic   out_matched_r;
  index_t out_index_r;
  word_t  out_operand_r;
  logic   out_second_r;

  logic   out_load;
  logic   in_load;

  logic   hit;
  index_t hit_index;
  word_t  hit_operand;
  logic   hit_second;

  assign out_load    = !out_valid_r || out_ch.ready;
  assign in_load     = !in_valid_r || out_load;
  assign in_ch.ready = in_load;

  // downward scan so the lowest matching entry is the one that sticks
  always_comb begin
    pattern_t p;
    word_t    f;
    hit         = 1'b0;
    hit_index   = '0;
    hit_operand = '0;
    hit_second  = 1'b0;
    for (int i = ENTRY_COUNT - 1; i >= 0; i--) begin
      p = opd_pattern(index_t'(i));
      f = p.fixed_free;
      if (p.kind == KIND_MEM) begin
        f = f | (in_word_r[7] ? MEM_INDIRECT_FREE : MEM_DIRECT_FREE);
      end
      if ((in_word_r & ~f) == p.base) begin
        hit         = 1'b1;
        hit_index   = index_t'(i);
        hit_operand = in_word_r & f;
        hit_second  = (p.kind == KIND_BRANCH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_load) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && in_ch.valid) begin
      in_word_r <= in_ch.instr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid_r) begin
      out_matched_r <= hit;
      out_index_r   <= hit_index;
      out_operand_r <= hit_operand;
      out_second_r  <= hit_second;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.matched      = out_matched_r;
  assign out_ch.entry_index  = out_index_r;
  assign out_ch.operand_bits = out_operand_r;
  assign out_ch.second_word  = out_second_r;

endmodule
`default_nettype wire

// ----- rtl/core/opd_checker.sv -----
`default_nettype none
module opd_checker
  import opd_pkg::*;
(
  input wire         clk,
  input wire         rst_n,
  input wire         out_valid,
  input wire         out_ready,
  input wire         out_matched,
  input wire [5:0]   out_entry_index,
  input wire [15:0]  out_operand_bits,
  input wire         out_second_word
);

  // a pending result word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_matched) && $stable(out_entry_index)
      && $stable(out_operand_bits) && $stable(out_second_word))
    else $error("result word changed while stalled");

  // illegal word reports all zero fields
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_entry_index == '0 &&
      out_operand_bits == '0 && !out_second_word)
    else $error("illegal word with nonzero fields");

  // branches match exactly and live at the end of the table
  a_branch_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_second_word |-> out_matched && out_operand_bits == '0 &&
      out_entry_index >= 6'd49)
    else $error("branch flagged with operand bits or wrong index");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_entry_index < 6'(ENTRY_COUNT))
    else $error("entry index beyond table");

endmodule

bind dsp_opcode_pattern_decoder_core opd_checker u_opd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_matched      (out_ch.matched),
  .out_entry_index  (out_ch.entry_index),
  .out_operand_bits (out_ch.operand_bits),
  .out_second_word  (out_ch.second_word)
);
`default_nettype wire

// ----- verif/dsp_opcode_pattern_decoder_core_test.sv -----
`default_nettype none
module dsp_opcode_pattern_decoder_core_test;
  import opd_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 250;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic   matched;
    index_t entry_index;
    word_t  operand_bits;
    logic   second_word;
  } decode_t;

  typedef struct packed {
    word_t   word;
    decode_t decode;
  } pending_t;

  logic clk;
  logic rst_n;

  opd_in_if  in_ch ();
  opd_out_if out_ch ();

  dsp_opcode_pattern_decoder_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pending_t pending_decodes[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_taken     = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int words_checked  = 0;
  int illegal_seen   = 0;
  int branch_seen    = 0;
  bit entry_hit [ENTRY_COUNT];

  // decode table, built from the layout of the opcode map
  function automatic pattern_t table_entry(input int i);
    pattern_t p;
    p = '{base: '0, fixed_free: '0, kind: KIND_NONE};
    if (i <= 2) begin
      p = '{word_t'(i) << 12, 16'h0F00, KIND_MEM};
    end else if (i <= 4) begin
      p = '{16'h3000 | (word_t'(i - 3) << 11), 16'h0100, KIND_MEM};
    end else if (i <= 8) begin
      p = '{16'h4000 + (word_t'(i - 5) << 11), 16'h0700, KIND_MEM};
    end else if (i <= 16) begin
      p = '{16'h6000 + (word_t'(i - 9) << 8), 16'h0000, KIND_MEM};
    end else if (i == 17) begin
      p = '{16'h6880, 16'h0001, KIND_NONE};
    end else if (i <= 23) begin
      p = '{16'h6800 + (word_t'(i - 18) << 8), 16'h0000, KIND_MEM};
    end else if (i == 24) begin
      p = '{16'h6E00, 16'h0001, KIND_NONE};
    end else if (i == 25) begin
      p = '{16'h6F00, 16'h0000, KIND_MEM};
    end else if (i == 26) begin
      p = '{16'h7000, 16'h01FF, KIND_NONE};
    end else if (i <= 32) begin
      p = '{16'h7800 + (word_t'(i - 27) << 8), 16'h0000, KIND_MEM};
    end else if (i == 33) begin
      p = '{16'h7E00, 16'h00FF, KIND_NONE};
    end else if (i <= 36) begin
      p = '{16'h7F80 + word_t'(i - 34), 16'h0000, KIND_NONE};
    end else if (i <= 44) begin
      p = '{16'h7F88 + word_t'(i - 37), 16'h0000, KIND_NONE};
    end else if (i == 45) begin
      p = '{16'h7F90, 16'h0000, KIND_NONE};
    end else if (i <= 47) begin
      p = '{16'h7F9C + word_t'(i - 46), 16'h0000, KIND_NONE};
    end else if (i == 48) begin
      p = '{16'h8000, 16'h1FFF, KIND_NONE};
    end else if (i <= 51) begin
      p = '{16'hF400 + (word_t'(i - 49) << 8), 16'h0000, KIND_BRANCH};
    end else begin
      p = '{16'hF800 + (word_t'(i - 52) << 8), 16'h0000, KIND_BRANCH};
    end
    return p;
  endfunction

  // first entry in table order wins
  function automatic decode_t decode_word(input word_t w);
    decode_t  d;
    pattern_t p;
    word_t    dont_care;
    bit       found;
    d = '0;
    found = 1'b0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      p = table_entry(i);
      dont_care = p.fixed_free;
      if (p.kind == KIND_MEM)
        dont_care = dont_care | (w[7] ? MEM_INDIRECT_FREE : MEM_DIRECT_FREE);
      if (!found && ((w & ~dont_care) == p.base)) begin
        found = 1'b1;
        d.matched      = 1'b1;
        d.entry_index  = index_t'(i);
        d.operand_bits = w & dont_care;
        d.second_word  = (p.kind == KIND_BRANCH);
      end
    end
    return d;
  endfunction

  // a word that fits entry i, with random operand bits
  function automatic word_t legal_word(input int i);
    pattern_t    p;
    logic [31:0] r;
    word_t       w;
    p = table_entry(i);
    r = $urandom;
    w = p.base | (r[15:0] & p.fixed_free);
    if (p.kind == KIND_MEM) begin
      if (r[16])
        w = w | 16'h0080 | (r[15:0] & MEM_INDIRECT_FREE);
      else
        w = w | (r[15:0] & MEM_DIRECT_FREE);
    end
    return w;
  endfunction

  function automatic word_t random_word();
    int    pick;
    int    bit_pos;
    word_t w;
    pick = $urandom_range(99);
    if (pick < 15) begin
      w = word_t'($urandom);
    end else begin
      w = legal_word($urandom_range(ENTRY_COUNT - 1));
      // broken pattern: one bit off a legal word
      if (pick < 32) begin
        bit_pos = $urandom_range(WORD_W - 1);
        w[bit_pos] = ~w[bit_pos];
      end
    end
    return w;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.instr_word = '0;
    out_ch.ready     = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken   <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  pending_t want;
  decode_t  got;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_decodes.push_back('{in_ch.instr_word, decode_word(in_ch.instr_word)});
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.matched, out_ch.entry_index, out_ch.operand_bits,
                out_ch.second_word};
        if (pending_decodes.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected decode word m=%0b idx=%0d ops=%h sw=%0b",
                     got.matched, got.entry_index, got.operand_bits, got.second_word);
        end else begin
          want = pending_decodes.pop_front();
          words_checked++;
          if (!want.decode.matched) illegal_seen++;
          else entry_hit[want.decode.entry_index] = 1'b1;
          if (want.decode.second_word) branch_seen++;
          if (got !== want.decode) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"mismatch for %h: expected m=%0b idx=%0d ops=%h sw=%0b,",
                        " got m=%0b idx=%0d ops=%h sw=%0b"},
                       want.word, want.decode.matched, want.decode.entry_index,
                       want.decode.operand_bits, want.decode.second_word,
                       got.matched, got.entry_index, got.operand_bits,
                       got.second_word);
          end
        end
      end
    end
  end

  // leaves valid high when the next word can follow at once
  task automatic send_word(input word_t w);
    in_ch.valid      <= 1'b1;
    in_ch.instr_word <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // waits on the clock first so the last accepted word is already queued
  task automatic stop_and_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    word_t words [$];
    words = '{16'h0000, 16'hFFFF, 16'h0F7F, 16'h00B9, 16'h00C0, 16'h0082,
              16'h6880, 16'h6881, 16'h6800, 16'h6882, 16'h68B9, 16'h6E01,
              16'h71FF, 16'h7EFF, 16'h7F00, 16'h7F80, 16'h7F83, 16'h7F9D,
              16'h9FFF, 16'hA000, 16'hF400, 16'hF401, 16'hF700, 16'hFF00};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (words[k]) send_word(words[k]);
    stop_and_drain();
  endtask

  task automatic test_random(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (count) send_word(random_word());
    stop_and_drain();
  endtask

  // receiver holds off long enough that the input side must stall
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked++;
    repeat (40) send_word(random_word());
    stop_and_drain();
  endtask

  int entries_hit;

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(370, 11, 53);
    test_random(370, 53, 11);
    test_backpressure();
    test_random(370, 0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_decodes.size() != 0) mismatches++;

    entries_hit = 0;
    foreach (entry_hit[k]) if (entry_hit[k]) entries_hit++;
    $display("decoded %0d words: %0d of %0d table entries hit, %0d illegal, %0d branch",
             words_checked, entries_hit, ENTRY_COUNT, illegal_seen, branch_seen);
    $display("ran with sender gaps, receiver stalls and one long output hold-off");
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
